// File: design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, codes and constants of the serial-line diagnostics server.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int LOG_DEPTH     = 32;
  localparam int LOG_AW        = $clog2(LOG_DEPTH);
  localparam int LOG_FW        = $clog2(LOG_DEPTH + 1);
  localparam int MAX_PDU_BYTES = 253;
  localparam int HDR_MAX       = 8;
  localparam int HDR_AW        = $clog2(HDR_MAX);
  localparam int HDR_LW        = $clog2(HDR_MAX + 1);
  localparam int NCNT          = 9;

  localparam logic [3:0] CMD_REQUEST   = 4'd0;
  localparam logic [3:0] CMD_BUS_MSG   = 4'd1;
  localparam logic [3:0] CMD_SRV_MSG   = 4'd2;
  localparam logic [3:0] CMD_COMPLETE  = 4'd3;
  localparam logic [3:0] CMD_EXCEPTION = 4'd4;
  localparam logic [3:0] CMD_COMM_ERR  = 4'd5;
  localparam logic [3:0] CMD_OVERRUN   = 4'd6;
  localparam logic [3:0] CMD_TAKE_PEND = 4'd7;
  localparam logic [3:0] CMD_LOAD_DIAG = 4'd8;

  localparam logic [2:0] ST_RESP = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_NOT  = 3'd2;
  localparam logic [2:0] ST_BAD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [7:0] FC_EXC_STATUS = 8'h07;
  localparam logic [7:0] FC_DIAG       = 8'h08;
  localparam logic [7:0] FC_EVT_CNT    = 8'h0B;
  localparam logic [7:0] FC_EVT_LOG    = 8'h0C;

  localparam logic [15:0] SUB_ECHO      = 16'h0000;
  localparam logic [15:0] SUB_RESTART   = 16'h0001;
  localparam logic [15:0] SUB_DIAG_REG  = 16'h0002;
  localparam logic [15:0] SUB_LISTEN    = 16'h0004;
  localparam logic [15:0] SUB_CLEAR     = 16'h000A;
  localparam logic [15:0] SUB_CNT_FIRST = 16'h000B;
  localparam logic [15:0] SUB_CNT_LAST  = 16'h0012;
  localparam logic [15:0] SUB_CLR_OVR   = 16'h0014;

  localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_DATA = 8'h03;
  localparam logic [15:0] RESTART_CLR_LOG  = 16'hFF00;
  localparam logic [7:0]  EV_RESTART       = 8'h00;
  localparam logic [7:0]  EV_LISTEN        = 8'h04;
  localparam logic [7:0]  LOG_HDR_BYTES    = 8'd6;

  localparam logic [3:0] CNT_BUS_MSG  = 4'd0;
  localparam logic [3:0] CNT_COMM_ERR = 4'd1;
  localparam logic [3:0] CNT_BUS_EXC  = 4'd2;
  localparam logic [3:0] CNT_SRV_MSG  = 4'd3;
  localparam logic [3:0] CNT_NO_RESP  = 4'd4;
  localparam logic [3:0] CNT_NAK      = 4'd5;
  localparam logic [3:0] CNT_BUSY     = 4'd6;
  localparam logic [3:0] CNT_OVERRUN  = 4'd7;
  localparam logic [3:0] CNT_EVENT    = 4'd8;

  localparam logic [3:0] REG_ALLOW = 4'd0;
  localparam logic [3:0] REG_EXC   = 4'd4;
  localparam logic [3:0] REG_COMM  = 4'd8;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  function_code;
    logic [15:0] subfunction;
    logic [15:0] data_word;
    logic [7:0]  pdu_length;
    logic        broadcast;
    logic [7:0]  exc_sent;
    logic        overrun;
    logic        addressed_here;
    logic        no_reply;
    logic        skip_event_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] resp_byte;
    logic       last;
    logic       listen_only_now;
    logic [1:0] pending_out;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  allow_mask;
    logic [7:0]  exception_status_byte;
    logic [15:0] comm_status_word;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIX,
    S_HDR,
    S_LRD,
    S_LOG
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic log2;
    logic emit_hdr;
    logic log_rd;
    logic emit_log;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic hdr_last;
    logic has_log;
    logic log_last;
  } dp_stat_t;

  function automatic logic [7:0] tx_code(logic listen, logic [7:0] exc);
    logic [7:0] e;
    e = 8'h40;
    if (listen) e = e | 8'h20;
    if (exc >= 8'd1 && exc <= 8'd3) e = e | 8'h01;
    else if (exc == 8'd4) e = e | 8'h02;
    else if (exc == 8'd5 || exc == 8'd6) e = e | 8'h04;
    else if (exc == 8'd7) e = e | 8'h08;
    return e;
  endfunction

  function automatic logic [7:0] rx_code(logic listen, logic bc, logic err, logic ovr);
    return {1'b1, bc, listen, ovr, 2'b00, err, 1'b0};
  endfunction

endpackage

// File: design/sld_ctrl.sv
// ----------------------------------------------------------------------------
// sld_ctrl
// Sequencer: accepts an item, finishes the log update, walks the reply.
// ----------------------------------------------------------------------------
module sld_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sld_pkg::dp_stat_t  stat,
  output sld_pkg::dp_cmd_t   cmd
);

  sld_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sld_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sld_pkg::S_IDLE: if (in_valid) state_nxt = sld_pkg::S_FIX;
      sld_pkg::S_FIX:  state_nxt = sld_pkg::S_HDR;
      sld_pkg::S_HDR: begin
        if (stat.slot_free && stat.hdr_last)
          state_nxt = stat.has_log ? sld_pkg::S_LRD : sld_pkg::S_IDLE;
      end
      sld_pkg::S_LRD:  state_nxt = sld_pkg::S_LOG;
      sld_pkg::S_LOG: begin
        if (stat.slot_free)
          state_nxt = stat.log_last ? sld_pkg::S_IDLE : sld_pkg::S_LRD;
      end
      default: state_nxt = sld_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      sld_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sld_pkg::S_FIX: cmd.log2     = 1'b1;
      sld_pkg::S_HDR: cmd.emit_hdr = stat.slot_free;
      sld_pkg::S_LRD: cmd.log_rd   = 1'b1;
      sld_pkg::S_LOG: cmd.emit_log = stat.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/sld_datapath.sv
// ----------------------------------------------------------------------------
// sld_datapath
// Counters, event log memory, request decode, reply buffer and output stage.
// ----------------------------------------------------------------------------
module sld_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sld_pkg::cfg_t      cfg,
  input  sld_pkg::in_item_t  in_data,
  input  sld_pkg::dp_cmd_t   cmd,
  output sld_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output sld_pkg::out_item_t out_data
);

  logic [15:0] cnt_r [sld_pkg::NCNT];
  logic [15:0] diag_r;
  logic        listen_r;
  logic [1:0]  pend_r;
  logic [sld_pkg::LOG_AW-1:0] head_r;
  logic [sld_pkg::LOG_FW-1:0] fill_r;
  logic [7:0]  mem [sld_pkg::LOG_DEPTH];
  logic [7:0]  rd_r;

  logic [7:0]  hdr_r [sld_pkg::HDR_MAX];
  logic [sld_pkg::HDR_LW-1:0] hl_r;
  logic [sld_pkg::HDR_AW-1:0] k_r;
  logic [sld_pkg::LOG_FW-1:0] lcnt_r;
  logic [sld_pkg::LOG_FW-1:0] i_r;
  logic        single_r;
  logic [2:0]  st_r;
  logic [1:0]  pout_r;
  logic        p2_r;
  logic [7:0]  ev2_r;
  logic        out_valid_r;
  sld_pkg::out_item_t out_r;

  // decode results
  logic [2:0]  st_c;
  logic [7:0]  h_c [sld_pkg::HDR_MAX];
  logic [sld_pkg::HDR_LW-1:0] hl_c;
  logic        logrep_c;
  logic [sld_pkg::NCNT-1:0] inc_c;
  logic        wipe_c, clr_diag_c, clr_ovr_c, set_l_c, clr_l_c, take_c, ld_diag_c;
  logic [1:0]  pset_c;
  logic        lg_c, lclr_c, l2_c;
  logic [7:0]  lgev_c, l2ev_c;
  logic        quiet_c, refuse_c, exc_c, word_c;
  logic [7:0]  exc_code_c;
  logic [15:0] word_val_c;

  logic [15:0] dw;
  logic        wf;
  logic [7:0]  tx0;
  logic [4:0]  csel;

  always_comb begin
    dw   = (in_data.pdu_length < 8'd5) ? 16'h0000 : in_data.data_word;
    wf   = (in_data.pdu_length == 8'd5) && (dw == 16'h0000);
    tx0  = sld_pkg::tx_code(listen_r, 8'h00);
    csel = in_data.subfunction[4:0] - sld_pkg::SUB_CNT_FIRST[4:0];

    st_c = sld_pkg::ST_DONE;
    for (int j = 0; j < sld_pkg::HDR_MAX; j++) h_c[j] = 8'h00;
    hl_c = '0;
    logrep_c = 1'b0;
    inc_c = '0;
    wipe_c = 1'b0; clr_diag_c = 1'b0; clr_ovr_c = 1'b0;
    set_l_c = 1'b0; clr_l_c = 1'b0; take_c = 1'b0; ld_diag_c = 1'b0;
    pset_c = 2'b00;
    lg_c = 1'b0; lclr_c = 1'b0; l2_c = 1'b0;
    lgev_c = 8'h00; l2ev_c = 8'h00;
    quiet_c = 1'b0; refuse_c = 1'b0; exc_c = 1'b0; word_c = 1'b0;
    exc_code_c = sld_pkg::EXC_ILLEGAL_DATA;
    word_val_c = 16'h0000;

    unique case (in_data.cmd)
      sld_pkg::CMD_REQUEST: begin
        if (in_data.pdu_length == 8'd0 ||
            in_data.pdu_length > 8'(sld_pkg::MAX_PDU_BYTES)) begin
          st_c = sld_pkg::ST_BAD;
        end else if (in_data.function_code != sld_pkg::FC_EXC_STATUS &&
                     in_data.function_code != sld_pkg::FC_DIAG &&
                     in_data.function_code != sld_pkg::FC_EVT_CNT &&
                     in_data.function_code != sld_pkg::FC_EVT_LOG) begin
          st_c = sld_pkg::ST_NOT;
        end else if (listen_r && !(in_data.function_code == sld_pkg::FC_DIAG &&
                                   in_data.pdu_length >= 8'd3 &&
                                   in_data.subfunction == sld_pkg::SUB_RESTART)) begin
          st_c = sld_pkg::ST_NONE;
        end else if (in_data.function_code == sld_pkg::FC_DIAG) begin
          if (in_data.pdu_length < 8'd3 || !in_data.pdu_length[0]) begin
            refuse_c = 1'b1;
          end else if (in_data.subfunction == sld_pkg::SUB_ECHO) begin
            if (in_data.broadcast) quiet_c = 1'b1;
            else begin
              st_c = sld_pkg::ST_RESP;
              h_c[0] = sld_pkg::FC_DIAG;
              h_c[1] = in_data.subfunction[15:8];
              h_c[2] = in_data.subfunction[7:0];
              h_c[3] = dw[15:8];
              h_c[4] = dw[7:0];
              hl_c = (in_data.pdu_length >= 8'd5) ? sld_pkg::HDR_LW'(5)
                                                  : sld_pkg::HDR_LW'(3);
            end
          end else if (in_data.subfunction == sld_pkg::SUB_RESTART) begin
            if (in_data.pdu_length != 8'd5 ||
                (dw != 16'h0000 && dw != sld_pkg::RESTART_CLR_LOG)) begin
              refuse_c = 1'b1;
            end else if (!cfg.allow_mask[0]) begin
              if (in_data.broadcast || listen_r) begin
                st_c = sld_pkg::ST_NONE;
                lg_c = 1'b1;
                lgev_c = tx0;
                inc_c[sld_pkg::CNT_NO_RESP] = !in_data.broadcast;
              end else begin
                exc_c = 1'b1;
              end
            end else begin
              wipe_c = 1'b1;
              clr_l_c = 1'b1;
              pset_c[0] = 1'b1;
              lclr_c = (dw == sld_pkg::RESTART_CLR_LOG);
              lg_c = 1'b1;
              lgev_c = sld_pkg::EV_RESTART;
              if (in_data.broadcast || listen_r) st_c = sld_pkg::ST_NONE;
              else begin
                word_c = 1'b1;
                word_val_c = dw;
              end
            end
          end else if (in_data.subfunction == sld_pkg::SUB_DIAG_REG) begin
            if (in_data.broadcast) quiet_c = 1'b1;
            else if (!wf) exc_c = 1'b1;
            else begin
              word_c = 1'b1;
              word_val_c = diag_r;
            end
          end else if (in_data.subfunction == sld_pkg::SUB_LISTEN) begin
            if (!wf || !cfg.allow_mask[1]) refuse_c = 1'b1;
            else begin
              st_c = sld_pkg::ST_NONE;
              set_l_c = 1'b1;
              inc_c[sld_pkg::CNT_EVENT] = 1'b1;
              inc_c[sld_pkg::CNT_NO_RESP] = !in_data.broadcast;
              lg_c = 1'b1;
              lgev_c = sld_pkg::tx_code(1'b1, 8'h00);
              l2_c = 1'b1;
              l2ev_c = sld_pkg::EV_LISTEN;
              pset_c[1] = 1'b1;
            end
          end else if (in_data.subfunction == sld_pkg::SUB_CLEAR) begin
            if (!wf || !cfg.allow_mask[2]) refuse_c = 1'b1;
            else begin
              wipe_c = 1'b1;
              clr_diag_c = 1'b1;
              lg_c = 1'b1;
              lgev_c = tx0;
              if (in_data.broadcast) st_c = sld_pkg::ST_NONE;
              else begin
                word_c = 1'b1;
                word_val_c = dw;
              end
            end
          end else if (in_data.subfunction >= sld_pkg::SUB_CNT_FIRST &&
                       in_data.subfunction <= sld_pkg::SUB_CNT_LAST) begin
            if (in_data.broadcast) quiet_c = 1'b1;
            else if (!wf) exc_c = 1'b1;
            else begin
              word_c = 1'b1;
              word_val_c = cnt_r[csel[3:0]];
            end
          end else if (in_data.subfunction == sld_pkg::SUB_CLR_OVR) begin
            if (!wf || !cfg.allow_mask[3]) refuse_c = 1'b1;
            else begin
              clr_ovr_c = 1'b1;
              if (in_data.broadcast) begin
                st_c = sld_pkg::ST_NONE;
                inc_c[sld_pkg::CNT_EVENT] = 1'b1;
                lg_c = 1'b1;
                lgev_c = tx0;
              end else begin
                word_c = 1'b1;
                word_val_c = dw;
              end
            end
          end else begin
            if (in_data.broadcast) quiet_c = 1'b1;
            else begin
              exc_c = 1'b1;
              exc_code_c = sld_pkg::EXC_ILLEGAL_FUNC;
            end
          end
        end else if (in_data.broadcast) begin
          quiet_c = 1'b1;
        end else if (in_data.pdu_length != 8'd1) begin
          exc_c = 1'b1;
        end else begin
          st_c = sld_pkg::ST_RESP;
          h_c[0] = in_data.function_code;
          if (in_data.function_code == sld_pkg::FC_EXC_STATUS) begin
            h_c[1] = cfg.exception_status_byte;
            hl_c = sld_pkg::HDR_LW'(2);
          end else if (in_data.function_code == sld_pkg::FC_EVT_CNT) begin
            h_c[1] = cfg.comm_status_word[15:8];
            h_c[2] = cfg.comm_status_word[7:0];
            h_c[3] = cnt_r[sld_pkg::CNT_EVENT][15:8];
            h_c[4] = cnt_r[sld_pkg::CNT_EVENT][7:0];
            hl_c = sld_pkg::HDR_LW'(5);
          end else begin
            h_c[1] = sld_pkg::LOG_HDR_BYTES + 8'(fill_r);
            h_c[2] = cfg.comm_status_word[15:8];
            h_c[3] = cfg.comm_status_word[7:0];
            h_c[4] = cnt_r[sld_pkg::CNT_EVENT][15:8];
            h_c[5] = cnt_r[sld_pkg::CNT_EVENT][7:0];
            h_c[6] = cnt_r[sld_pkg::CNT_BUS_MSG][15:8];
            h_c[7] = cnt_r[sld_pkg::CNT_BUS_MSG][7:0];
            hl_c = sld_pkg::HDR_LW'(8);
            logrep_c = 1'b1;
          end
        end
      end
      sld_pkg::CMD_BUS_MSG: begin
        inc_c[sld_pkg::CNT_BUS_MSG] = 1'b1;
        lg_c = 1'b1;
        lgev_c = sld_pkg::rx_code(listen_r, in_data.broadcast, 1'b0, 1'b0);
      end
      sld_pkg::CMD_SRV_MSG: inc_c[sld_pkg::CNT_SRV_MSG] = 1'b1;
      sld_pkg::CMD_COMPLETE: begin
        inc_c[sld_pkg::CNT_EVENT] = !in_data.skip_event_count;
        inc_c[sld_pkg::CNT_NO_RESP] = in_data.no_reply;
        lg_c = 1'b1;
        lgev_c = tx0;
      end
      sld_pkg::CMD_EXCEPTION: begin
        inc_c[sld_pkg::CNT_BUS_EXC] = 1'b1;
        inc_c[sld_pkg::CNT_BUSY] = (in_data.exc_sent == 8'd6);
        inc_c[sld_pkg::CNT_NAK] = (in_data.exc_sent == 8'd7);
        lg_c = 1'b1;
        lgev_c = sld_pkg::tx_code(listen_r, in_data.exc_sent);
      end
      sld_pkg::CMD_COMM_ERR: begin
        inc_c[sld_pkg::CNT_BUS_MSG] = 1'b1;
        inc_c[sld_pkg::CNT_COMM_ERR] = 1'b1;
        inc_c[sld_pkg::CNT_OVERRUN] = in_data.overrun;
        lg_c = 1'b1;
        lgev_c = sld_pkg::rx_code(listen_r, in_data.broadcast, 1'b1, in_data.overrun);
      end
      sld_pkg::CMD_OVERRUN: begin
        inc_c[sld_pkg::CNT_BUS_MSG] = 1'b1;
        inc_c[sld_pkg::CNT_OVERRUN] = in_data.addressed_here;
        lg_c = 1'b1;
        lgev_c = sld_pkg::rx_code(listen_r, in_data.broadcast, 1'b0, 1'b1);
      end
      sld_pkg::CMD_TAKE_PEND: take_c = 1'b1;
      sld_pkg::CMD_LOAD_DIAG: ld_diag_c = 1'b1;
      default: st_c = sld_pkg::ST_NOT;
    endcase

    if (refuse_c) begin
      if (in_data.broadcast) quiet_c = 1'b1;
      else exc_c = 1'b1;
    end
    if (quiet_c) begin
      st_c = sld_pkg::ST_NONE;
      lg_c = 1'b1;
      lgev_c = tx0;
    end
    if (exc_c) begin
      st_c = sld_pkg::ST_RESP;
      h_c[0] = in_data.function_code | 8'h80;
      h_c[1] = exc_code_c;
      hl_c = sld_pkg::HDR_LW'(2);
    end
    if (word_c) begin
      st_c = sld_pkg::ST_RESP;
      h_c[0] = sld_pkg::FC_DIAG;
      h_c[1] = in_data.subfunction[15:8];
      h_c[2] = in_data.subfunction[7:0];
      h_c[3] = word_val_c[15:8];
      h_c[4] = word_val_c[7:0];
      hl_c = sld_pkg::HDR_LW'(5);
    end
  end

  // event log write port
  logic        wr_en;
  logic [7:0]  wr_ev;
  logic [sld_pkg::LOG_AW-1:0] head_b, head_w;
  logic [sld_pkg::LOG_FW-1:0] fill_b, fill_w;

  always_comb begin
    wr_en  = (cmd.accept && lg_c) || (cmd.log2 && p2_r);
    wr_ev  = cmd.accept ? lgev_c : ev2_r;
    head_b = (cmd.accept && lclr_c) ? '0 : head_r;
    fill_b = (cmd.accept && lclr_c) ? '0 : fill_r;
    if (fill_b == '0)           head_w = '0;
    else if (head_b == '0)      head_w = sld_pkg::LOG_AW'(sld_pkg::LOG_DEPTH - 1);
    else                        head_w = head_b - 1'b1;
    fill_w = (fill_b < sld_pkg::LOG_FW'(sld_pkg::LOG_DEPTH)) ? fill_b + 1'b1 : fill_b;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[head_w] <= wr_ev;
    if (cmd.log_rd) rd_r <= mem[head_r + i_r[sld_pkg::LOG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < sld_pkg::NCNT; j++) cnt_r[j] <= 16'h0000;
      diag_r   <= 16'h0000;
      listen_r <= 1'b0;
      pend_r   <= 2'b00;
      head_r   <= '0;
      fill_r   <= '0;
      p2_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        head_r <= head_w;
        fill_r <= fill_w;
      end
      if (cmd.log2) p2_r <= 1'b0;
      if (cmd.accept) begin
        for (int j = 0; j < sld_pkg::NCNT; j++) begin
          logic [15:0] b;
          b = (wipe_c || (clr_ovr_c && j == int'(sld_pkg::CNT_OVERRUN))) ? 16'h0000
                                                                         : cnt_r[j];
          cnt_r[j] <= (inc_c[j] && b != 16'hFFFF) ? b + 16'h0001 : b;
        end
        if (clr_diag_c)     diag_r <= 16'h0000;
        else if (ld_diag_c) diag_r <= in_data.data_word;
        if (set_l_c)        listen_r <= 1'b1;
        else if (clr_l_c)   listen_r <= 1'b0;
        pend_r <= take_c ? 2'b00 : (pend_r | pset_c);
        p2_r   <= l2_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int j = 0; j < sld_pkg::HDR_MAX; j++) hdr_r[j] <= h_c[j];
      hl_r     <= hl_c;
      lcnt_r   <= logrep_c ? fill_r : '0;
      single_r <= (st_c != sld_pkg::ST_RESP);
      st_r     <= st_c;
      pout_r   <= take_c ? pend_r : 2'b00;
      ev2_r    <= l2ev_c;
      k_r      <= '0;
      i_r      <= '0;
    end else begin
      if (cmd.emit_hdr) k_r <= k_r + 1'b1;
      if (cmd.emit_log) i_r <= i_r + 1'b1;
    end
  end

  always_comb begin
    stat.slot_free = !out_valid_r || out_ready;
    stat.hdr_last  = single_r || ({1'b0, k_r} == hl_r - 1'b1);
    stat.has_log   = (lcnt_r != '0);
    stat.log_last  = (i_r == lcnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_hdr || cmd.emit_log) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr) begin
      if (single_r) begin
        out_r <= '{status: st_r, resp_byte: 8'h00, last: 1'b1,
                   listen_only_now: listen_r, pending_out: pout_r};
      end else begin
        out_r <= '{status: sld_pkg::ST_RESP, resp_byte: hdr_r[k_r],
                   last: stat.hdr_last && !stat.has_log,
                   listen_only_now: listen_r, pending_out: 2'b00};
      end
    end else if (cmd.emit_log) begin
      out_r <= '{status: sld_pkg::ST_RESP, resp_byte: rd_r, last: stat.log_last,
                 listen_only_now: listen_r, pending_out: 2'b00};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/serial_line_diagnostics_server_top.sv
// ----------------------------------------------------------------------------
// serial_line_diagnostics_server_top
// Serial-line diagnostic counters, event log and diagnostics request server.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one bus event or request per transfer (valid/ready).
//   out_*  : result items; a request reply is a byte stream closed by last,
//            every other input gives a single item with last set.
//   APB    : allow_mask at 0x0, exception status byte at 0x4, comm status
//            word at 0x8; write only while the block is idle.
// Timing:
//   An item is taken in S_IDLE and S_FIX completes its log update; then
//   S_HDR sends each header byte (up to 8) while the output register is
//   free, and each event log byte is read from the single read port of the
//   32-entry log memory into a register in S_LRD and sent in S_LOG. The next
//   item is taken once the last result has entered the output register.
// Reset clears counters, flags, log pointers and the state, valid and config
// registers; log memory contents are not cleared. A stalled receiver holds the
// output register and the reply walk waits.
// ----------------------------------------------------------------------------
module serial_line_diagnostics_server_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sld_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sld_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sld_pkg::cfg_t     cfg_r;
  sld_pkg::dp_cmd_t  cmd;
  sld_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        sld_pkg::REG_ALLOW: cfg_r.allow_mask            <= pwdata[3:0];
        sld_pkg::REG_EXC:   cfg_r.exception_status_byte <= pwdata[7:0];
        sld_pkg::REG_COMM:  cfg_r.comm_status_word      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      sld_pkg::REG_ALLOW: prdata = {28'h0, cfg_r.allow_mask};
      sld_pkg::REG_EXC:   prdata = {24'h0, cfg_r.exception_status_byte};
      sld_pkg::REG_COMM:  prdata = {16'h0, cfg_r.comm_status_word};
      default:            prdata = 32'h0;
    endcase
  end

  assign pready = 1'b1;

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sld_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/sld_checker.sv
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the serial-line diagnostics server.
// ----------------------------------------------------------------------------
module sld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sld_pkg::out_item_t out_data,
  input logic               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != sld_pkg::ST_RESP |-> out_data.last)
    else $error("status item not marked last");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != sld_pkg::ST_RESP |-> out_data.resp_byte == 8'h00)
    else $error("status item carries a byte");

  a_pend_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pending_out != 2'b00 |-> out_data.status == sld_pkg::ST_DONE)
    else $error("pending flags on a non-event item");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind serial_line_diagnostics_server_top sld_checker u_sld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
